>>> hw/rtl/cmg_pkg.sv
`timescale 1ns / 1ps

package cmg_pkg;

  localparam int MAX_GRID_ROWS   = 16;
  localparam int MAX_GRID_COLS   = 16;
  localparam int SHAPES_PER_CELL = 8;

  localparam int NUM_CELLS   = MAX_GRID_ROWS * MAX_GRID_COLS;
  localparam int STORE_DEPTH = NUM_CELLS * SHAPES_PER_CELL;

  localparam int ROW_W   = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
  localparam int COL_W   = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
  localparam int CELL_W  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int SLOT_W  = (SHAPES_PER_CELL > 1) ? $clog2(SHAPES_PER_CELL) : 1;
  localparam int FILL_W  = $clog2(SHAPES_PER_CELL + 1);
  localparam int STORE_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int COORD_W = 12;
  localparam int SQ_W    = 24;
  localparam int CFG_W   = 13;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1024;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1024;
  localparam logic [CFG_W-1:0] CELL_SIZE_RST    = 13'd256;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_TOO_BIG = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_CELL_SIZE    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [SQ_W-1:0]    sq_radius;
  } item_t;

  typedef struct packed {
    logic       masked;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic [CFG_W-1:0] cell_size;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SQ_W-1:0]    sq;
  } circle_t;

  typedef struct packed {
    logic [1:0]         op;
    status_e            status;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SQ_W-1:0]    sq;
    logic [ROW_W-1:0]   rlo;
    logic [ROW_W-1:0]   rhi;
    logic [COL_W-1:0]   clo;
    logic [COL_W-1:0]   chi;
  } job_t;

endpackage

>>> hw/rtl/cmg_front.sv
`timescale 1ns / 1ps

module cmg_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  cmg_pkg::item_t item_i,
  input  cmg_pkg::cfg_t  cfg_i,
  output logic           busy_o,
  input  logic           full_i,
  output logic           push_o,
  output cmg_pkg::job_t  job_o
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_DIVY = 4'b0010,
    F_DIVX = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_e;

  fstate_e state_q, state_d;

  logic [1:0]                  cmd_q, cmd_d;
  logic [cmg_pkg::COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic [cmg_pkg::SQ_W-1:0]    sq_q, sq_d;
  cmg_pkg::status_e            status_q, status_d;
  logic [cmg_pkg::COORD_W-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [cmg_pkg::CFG_W-1:0]   rem_q, rem_d;
  logic [3:0]                  cnt_q, cnt_d;
  logic [cmg_pkg::ROW_W-1:0]   r0_q, r0_d;
  logic [cmg_pkg::COL_W-1:0]   c0_q, c0_d;
  logic                        rbig_q, rbig_d, cbig_q, cbig_d;

  logic [cmg_pkg::CFG_W-1:0]   cs;
  logic [cmg_pkg::CFG_W:0]     trial;
  logic                        ge;
  logic [cmg_pkg::CFG_W-1:0]   rem_n;
  logic [cmg_pkg::COORD_W-1:0] quo_n;
  logic                        outside;
  logic                        is_add;

  logic [cmg_pkg::ROW_W:0]                 rinc;
  logic [cmg_pkg::COL_W:0]                 cinc;
  logic [cmg_pkg::ROW_W+cmg_pkg::CFG_W:0]  rprod;
  logic [cmg_pkg::COL_W+cmg_pkg::CFG_W:0]  cprod;
  logic [2*cmg_pkg::CFG_W-1:0]             cs_sq;
  logic                                    rhi_ok, chi_ok, too_big;
  cmg_pkg::status_e                        status_f;

  assign cs = (cfg_i.cell_size == '0) ? cmg_pkg::CFG_W'(1) : cfg_i.cell_size;

  // One restoring division step: one quotient bit per cycle.
  assign trial = {rem_q, dvd_q[cmg_pkg::COORD_W-1]};
  assign ge    = trial >= {1'b0, cs};
  assign rem_n = ge ? cmg_pkg::CFG_W'(trial - {1'b0, cs}) : cmg_pkg::CFG_W'(trial);
  assign quo_n = {quo_q[cmg_pkg::COORD_W-2:0], ge};

  assign outside = ({1'b0, item_i.x_coord} >= cfg_i.frame_width)
                || ({1'b0, item_i.y_coord} >= cfg_i.frame_height);
  assign is_add  = (cmd_q == cmg_pkg::CMD_ADD);

  // A neighbour row exists when r0 + 1 is below MAX_GRID_ROWS and (r0 + 1) * cell_size is still inside the frame.
  assign rinc   = {1'b0, r0_q} + (cmg_pkg::ROW_W+1)'(1);
  assign cinc   = {1'b0, c0_q} + (cmg_pkg::COL_W+1)'(1);
  assign rprod  = rinc * cs;
  assign cprod  = cinc * cs;
  assign rhi_ok = (rinc < (cmg_pkg::ROW_W+1)'(cmg_pkg::MAX_GRID_ROWS))
               && (rprod < (cmg_pkg::ROW_W+cmg_pkg::CFG_W+1)'(cfg_i.frame_height));
  assign chi_ok = (cinc < (cmg_pkg::COL_W+1)'(cmg_pkg::MAX_GRID_COLS))
               && (cprod < (cmg_pkg::COL_W+cmg_pkg::CFG_W+1)'(cfg_i.frame_width));
  assign cs_sq   = cs * cs;
  assign too_big = {2'b00, sq_q} > cs_sq;

  always_comb begin
    if (status_q != cmg_pkg::ST_OK) begin
      status_f = status_q;
    end else if (rbig_q || cbig_q) begin
      status_f = cmg_pkg::ST_OUTSIDE;
    end else if (is_add && too_big) begin
      status_f = cmg_pkg::ST_TOO_BIG;
    end else begin
      status_f = cmg_pkg::ST_OK;
    end
  end

  always_comb begin
    job_o.op     = cmd_q;
    job_o.status = status_f;
    job_o.x      = x_q;
    job_o.y      = y_q;
    job_o.sq     = sq_q;
    if (is_add) begin
      job_o.rlo = r0_q;
      job_o.rhi = r0_q;
      job_o.clo = c0_q;
      job_o.chi = c0_q;
    end else begin
      job_o.rlo = (r0_q == '0) ? r0_q : r0_q - cmg_pkg::ROW_W'(1);
      job_o.rhi = rhi_ok ? rinc[cmg_pkg::ROW_W-1:0] : r0_q;
      job_o.clo = (c0_q == '0) ? c0_q : c0_q - cmg_pkg::COL_W'(1);
      job_o.chi = chi_ok ? cinc[cmg_pkg::COL_W-1:0] : c0_q;
    end
  end

  assign busy_o = (state_q != F_IDLE);
  assign push_o = (state_q == F_PUSH) && !full_i;

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    x_d      = x_q;
    y_d      = y_q;
    sq_d     = sq_q;
    status_d = status_q;
    dvd_d    = dvd_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    r0_d     = r0_q;
    c0_d     = c0_q;
    rbig_d   = rbig_q;
    cbig_d   = cbig_q;
    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          cmd_d  = item_i.cmd;
          x_d    = item_i.x_coord;
          y_d    = item_i.y_coord;
          sq_d   = item_i.sq_radius;
          rbig_d = 1'b0;
          cbig_d = 1'b0;
          r0_d   = '0;
          c0_d   = '0;
          if ((item_i.cmd == cmg_pkg::CMD_ADD) || (item_i.cmd == cmg_pkg::CMD_QUERY)) begin
            if (outside) begin
              status_d = cmg_pkg::ST_OUTSIDE;
              state_d  = F_PUSH;
            end else begin
              status_d = cmg_pkg::ST_OK;
              dvd_d    = item_i.y_coord;
              rem_d    = '0;
              cnt_d    = 4'(cmg_pkg::COORD_W - 1);
              state_d  = F_DIVY;
            end
          end else begin
            status_d = cmg_pkg::ST_OK;
            state_d  = F_PUSH;
          end
        end
      end
      F_DIVY: begin
        dvd_d = {dvd_q[cmg_pkg::COORD_W-2:0], 1'b0};
        rem_d = rem_n;
        quo_d = quo_n;
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == '0) begin
          rbig_d  = quo_n >= cmg_pkg::COORD_W'(cmg_pkg::MAX_GRID_ROWS);
          r0_d    = quo_n[cmg_pkg::ROW_W-1:0];
          dvd_d   = x_q;
          rem_d   = '0;
          cnt_d   = 4'(cmg_pkg::COORD_W - 1);
          state_d = F_DIVX;
        end
      end
      F_DIVX: begin
        dvd_d = {dvd_q[cmg_pkg::COORD_W-2:0], 1'b0};
        rem_d = rem_n;
        quo_d = quo_n;
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == '0) begin
          cbig_d  = quo_n >= cmg_pkg::COORD_W'(cmg_pkg::MAX_GRID_COLS);
          c0_d    = quo_n[cmg_pkg::COL_W-1:0];
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    x_q      <= x_d;
    y_q      <= y_d;
    sq_q     <= sq_d;
    status_q <= status_d;
    dvd_q    <= dvd_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
    r0_q     <= r0_d;
    c0_q     <= c0_d;
    rbig_q   <= rbig_d;
    cbig_q   <= cbig_d;
  end

endmodule

>>> hw/rtl/cmg_queue.sv
`timescale 1ns / 1ps

module cmg_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmg_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output cmg_pkg::job_t head_o
);

  localparam int PTR_W = (cmg_pkg::QUEUE_DEPTH > 1) ? $clog2(cmg_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(cmg_pkg::QUEUE_DEPTH + 1);

  cmg_pkg::job_t     mem_q [cmg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(cmg_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(cmg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(cmg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

>>> hw/rtl/cmg_back.sv
`timescale 1ns / 1ps

module cmg_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  cmg_pkg::job_t    head_i,
  output logic             pop_o,
  output logic             done_o,
  output cmg_pkg::result_t result_o
);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_FRD   = 5'b00010,
    B_FCHK  = 5'b00100,
    B_SCAN  = 5'b01000,
    B_DRAIN = 5'b10000
  } bstate_e;

  bstate_e state_q, state_d;

  cmg_pkg::job_t              job_q, job_d;
  logic [cmg_pkg::ROW_W-1:0]  r_q, r_d;
  logic [cmg_pkg::COL_W-1:0]  c_q, c_d;
  logic [cmg_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [cmg_pkg::FILL_W-1:0] n_q, n_d;
  logic                       res_valid_q, res_valid_d;
  cmg_pkg::result_t           res_q, res_d;

  // Fill counts live in a memory; a cleared valid bit reads as zero.
  logic [cmg_pkg::FILL_W-1:0] fill_mem [cmg_pkg::NUM_CELLS];
  logic [cmg_pkg::NUM_CELLS-1:0] fill_vld_q;
  logic [cmg_pkg::FILL_W-1:0] fill_rd_q;
  logic                       fill_rdv_q;
  logic                       fill_we, clear_all;
  logic [cmg_pkg::FILL_W-1:0] n_cur;

  cmg_pkg::circle_t           store_mem [cmg_pkg::STORE_DEPTH];
  cmg_pkg::circle_t           store_rd_q;
  logic                       store_we;
  logic [cmg_pkg::SLOT_W-1:0] slot_sel;
  logic [cmg_pkg::STORE_AW-1:0] store_addr;
  cmg_pkg::circle_t           store_wdata;

  logic [cmg_pkg::CELL_W-1:0] cell_idx;
  logic                       last_cell;

  // Distance pipeline: read word, squared differences, compare.
  logic                       issue, flush;
  logic                       v1_q, v2_q;
  logic [cmg_pkg::COORD_W-1:0] dx, dy;
  logic [2*cmg_pkg::COORD_W-1:0] px_q, py_q;
  logic [cmg_pkg::SQ_W-1:0]   sq2_q;
  logic [2*cmg_pkg::COORD_W:0] dist_sum;
  logic                       hit;

  assign cell_idx = cmg_pkg::CELL_W'(32'(r_q) * cmg_pkg::MAX_GRID_COLS + 32'(c_q));
  assign n_cur    = fill_rdv_q ? fill_rd_q : '0;
  assign slot_sel = (state_q == B_FCHK) ? n_cur[cmg_pkg::SLOT_W-1:0] : slot_q;
  assign store_addr = cmg_pkg::STORE_AW'(32'(cell_idx) * cmg_pkg::SHAPES_PER_CELL
                                        + 32'(slot_sel));
  assign store_wdata = '{x: job_q.x, y: job_q.y, sq: job_q.sq};
  assign last_cell = (r_q == job_q.rhi) && (c_q == job_q.chi);

  assign dx   = (store_rd_q.x > job_q.x) ? store_rd_q.x - job_q.x : job_q.x - store_rd_q.x;
  assign dy   = (store_rd_q.y > job_q.y) ? store_rd_q.y - job_q.y : job_q.y - store_rd_q.y;
  assign dist_sum = {1'b0, px_q} + {1'b0, py_q};
  assign hit  = v2_q && (dist_sum < (2*cmg_pkg::COORD_W+1)'(sq2_q));

  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign done_o   = res_valid_q;
  assign result_o = res_q;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    r_d         = r_q;
    c_d         = c_q;
    slot_d      = slot_q;
    n_d         = n_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    fill_we     = 1'b0;
    store_we    = 1'b0;
    clear_all   = 1'b0;
    issue       = 1'b0;
    flush       = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          job_d = head_i;
          r_d   = head_i.rlo;
          c_d   = head_i.clo;
          if ((head_i.status == cmg_pkg::ST_OK)
              && ((head_i.op == cmg_pkg::CMD_ADD) || (head_i.op == cmg_pkg::CMD_QUERY))) begin
            state_d = B_FRD;
          end else begin
            res_valid_d = 1'b1;
            res_d       = '{masked: 1'b0, status: head_i.status};
            clear_all   = (head_i.op == cmg_pkg::CMD_CLEAR);
          end
        end
      end
      B_FRD: begin
        if (hit) begin
          res_valid_d = 1'b1;
          res_d       = '{masked: 1'b1, status: cmg_pkg::ST_OK};
          flush       = 1'b1;
          state_d     = B_IDLE;
        end else begin
          state_d = B_FCHK;
        end
      end
      B_FCHK: begin
        if (hit) begin
          res_valid_d = 1'b1;
          res_d       = '{masked: 1'b1, status: cmg_pkg::ST_OK};
          flush       = 1'b1;
          state_d     = B_IDLE;
        end else if (job_q.op == cmg_pkg::CMD_ADD) begin
          res_valid_d = 1'b1;
          state_d     = B_IDLE;
          if (n_cur >= cmg_pkg::FILL_W'(cmg_pkg::SHAPES_PER_CELL)) begin
            res_d = '{masked: 1'b0, status: cmg_pkg::ST_FULL};
          end else begin
            res_d    = '{masked: 1'b0, status: cmg_pkg::ST_OK};
            store_we = 1'b1;
            fill_we  = 1'b1;
          end
        end else if (n_cur != '0) begin
          slot_d  = '0;
          n_d     = n_cur;
          state_d = B_SCAN;
        end else if (last_cell) begin
          state_d = B_DRAIN;
        end else if (c_q == job_q.chi) begin
          r_d     = r_q + cmg_pkg::ROW_W'(1);
          c_d     = job_q.clo;
          state_d = B_FRD;
        end else begin
          c_d     = c_q + cmg_pkg::COL_W'(1);
          state_d = B_FRD;
        end
      end
      B_SCAN: begin
        if (hit) begin
          res_valid_d = 1'b1;
          res_d       = '{masked: 1'b1, status: cmg_pkg::ST_OK};
          flush       = 1'b1;
          state_d     = B_IDLE;
        end else begin
          issue = 1'b1;
          if (cmg_pkg::FILL_W'(slot_q) == n_q - cmg_pkg::FILL_W'(1)) begin
            if (last_cell) begin
              state_d = B_DRAIN;
            end else if (c_q == job_q.chi) begin
              r_d     = r_q + cmg_pkg::ROW_W'(1);
              c_d     = job_q.clo;
              state_d = B_FRD;
            end else begin
              c_d     = c_q + cmg_pkg::COL_W'(1);
              state_d = B_FRD;
            end
          end else begin
            slot_d = slot_q + cmg_pkg::SLOT_W'(1);
          end
        end
      end
      B_DRAIN: begin
        if (hit || (!v1_q && !v2_q)) begin
          res_valid_d = 1'b1;
          res_d       = '{masked: hit, status: cmg_pkg::ST_OK};
          flush       = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      res_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      fill_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      v1_q        <= issue;
      v2_q        <= v1_q && !flush;
      if (clear_all) begin
        fill_vld_q <= '0;
      end else if (fill_we) begin
        fill_vld_q[cell_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    r_q    <= r_d;
    c_q    <= c_d;
    slot_q <= slot_d;
    n_q    <= n_d;
    res_q  <= res_d;
    px_q   <= dx * dx;
    py_q   <= dy * dy;
    sq2_q  <= store_rd_q.sq;
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[cell_idx] <= n_cur + cmg_pkg::FILL_W'(1);
    end
    fill_rd_q  <= fill_mem[cell_idx];
    fill_rdv_q <= fill_vld_q[cell_idx];
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_addr] <= store_wdata;
    end
    store_rd_q <= store_mem[store_addr];
  end

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_IDLE) |-> (!v1_q && !v2_q))
    else $error("distance pipeline busy while the back end is idle");

  a_hit_only_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> (job_q.op == cmg_pkg::CMD_QUERY))
    else $error("distance hit outside a query");

  a_masked_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.masked) |-> (res_q.status == cmg_pkg::ST_OK))
    else $error("masked word carries a failure status");

  a_write_add_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> ((job_q.op == cmg_pkg::CMD_ADD) && fill_we))
    else $error("circle store written outside an add");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ($past(state_q) != B_IDLE || $past(pop_o)))
    else $error("result word without a job");

endmodule

>>> hw/rtl/circle_mask_grid_core.sv
`timescale 1ns / 1ps

// Grid of circles with point-in-circle queries.
// Command channel: an item (add, query, clear) is taken at a clock edge with
// start_i high and busy_o low. Each command gives exactly one result word on
// result_o, marked by done_o for a single cycle; the receiver cannot stall,
// so a result is never held back.
// The front end checks the frame and, for an add or query inside it, divides
// y and x by the cell size, one quotient bit per cycle. A two-entry queue
// then hands the job to the back end, which reads the fill count of each
// cell and, for a query, streams one stored circle per cycle through a
// three-stage distance pipeline. An add stores its circle unless the cell is
// full; a query scans up to 9 cells, ending early on a hit. The back end
// overlaps the next item's division, so the sustained rate is set by the
// slower of the divider and the cell scan.
// The user must write configuration through cfg_we_i, cfg_idx_i and
// cfg_data_i only while the block is idle; the block does not enforce this.
// Reset restores 1024 x 1024 frame with 256-pixel cells and empties every
// cell at once; no clearing pass is needed.

module circle_mask_grid_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  cmg_pkg::item_t               item_i,
  output logic                         busy_o,
  output logic                         done_o,
  output cmg_pkg::result_t             result_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [cmg_pkg::CFG_W-1:0]    cfg_data_i
);

  cmg_pkg::cfg_t cfg_q, cfg_d;
  cmg_pkg::job_t push_job, head_job;
  logic          push, pop, full, empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        cmg_pkg::CFG_FRAME_WIDTH:  cfg_d.frame_width  = cfg_data_i;
        cmg_pkg::CFG_FRAME_HEIGHT: cfg_d.frame_height = cfg_data_i;
        cmg_pkg::CFG_CELL_SIZE:    cfg_d.cell_size    = cfg_data_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= cmg_pkg::FRAME_WIDTH_RST;
      cfg_q.frame_height <= cmg_pkg::FRAME_HEIGHT_RST;
      cfg_q.cell_size    <= cmg_pkg::CELL_SIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cmg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .cfg_i   (cfg_q),
    .busy_o  (busy_o),
    .full_i  (full),
    .push_o  (push),
    .job_o   (push_job)
  );

  cmg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head_job)
  );

  cmg_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .head_i   (head_job),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
